// ----- rtl/core/rtc_pkg.sv -----
// Shared types and codes for the transmit-ring credit tracker.
// No dependencies; used by the top level and its checker.
`default_nettype none

package rtc_pkg;

  typedef logic [1:0] op_t;
  typedef logic [2:0] status_t;

  localparam op_t OP_OBSERVE = 2'd0;
  localparam op_t OP_SUBMIT  = 2'd1;
  localparam op_t OP_REPORT  = 2'd2;

  localparam status_t ST_OBSERVED  = 3'd0;
  localparam status_t ST_ACCEPTED  = 3'd1;
  localparam status_t ST_DROPPED   = 3'd2;
  localparam status_t ST_REPORTED  = 3'd3;
  localparam status_t ST_NO_REPORT = 3'd4;

  // Mirror half-word of a cursor that has wrapped an odd number of times.
  localparam logic [15:0] MIRROR_ONES = 16'hffff;

endpackage

`default_nettype wire

// ----- rtl/core/ring_tx_credit_tracker.sv -----
// Transmit-ring credit tracker: one request at a time, one result per request.
// A request is taken only while the sequencer is idle. It then checks the
// cursors, decides on accounting, examines the credit FIFO entries one by one
// (at most CREDIT_SLOTS, one read of the credit memory per cycle) and forms
// the result; a new request is not taken until that result is formed.
// The result sits in an output register; the next request is taken while it
// waits, and only the final step waits for that register to be free.
// Depends on rtc_pkg.
`default_nettype none

module ring_tx_credit_tracker #(
  parameter int RING_CAPACITY = 1024,
  parameter int CREDIT_SLOTS  = 8,
  parameter int MAX_TX_LENGTH = 120
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire rtc_pkg::op_t    in_operation,
  input  wire [31:0]           in_read_cursor,
  input  wire [31:0]           in_write_cursor,
  input  wire                  in_descriptor_ok,
  input  wire                  in_link_ok,
  input  wire [7:0]            in_packet_length,
  output logic                 out_valid,
  input  wire                  out_ready,
  output rtc_pkg::status_t     out_status,
  output logic [31:0]          out_next_write_cursor,
  output logic [15:0]          out_completed_count,
  output logic [3:0]           out_retired_packets
);

  localparam int CW = $clog2(CREDIT_SLOTS + 1);
  localparam int HW = (CREDIT_SLOTS > 1) ? $clog2(CREDIT_SLOTS) : 1;
  localparam int SW = CW + 1;

  localparam logic [15:0] RC16  = 16'(RING_CAPACITY);
  localparam logic [16:0] RC17  = 17'(RING_CAPACITY);
  localparam logic [17:0] RC18  = 18'(RING_CAPACITY);
  localparam logic [CW-1:0] SLOTS_C = CW'(CREDIT_SLOTS);
  localparam logic [SW-1:0] SLOTS_S = SW'(CREDIT_SLOTS);
  localparam logic [HW:0] SLOTS_H = (HW + 1)'(CREDIT_SLOTS);
  localparam logic [7:0] MAX_LEN = 8'(MAX_TX_LENGTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FILL   = 3'd1;
  localparam logic [2:0] S_ACCT   = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0]  state_r, state_nxt;

  // Request fields held for the duration of the work.
  rtc_pkg::op_t op_r;
  logic [31:0] rc_r, wc_r;
  logic        desc_r, link_r;
  logic [7:0]  len_r;

  logic        fill_ok_r;
  logic [16:0] avail_r;
  logic [15:0] drained_r, drained_nxt;
  logic [CW-1:0] retired_r, retired_nxt;

  logic [HW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0] bif_r, bif_nxt;
  logic [15:0] tally_r, tally_nxt;
  logic        fce_r;

  // Credit FIFO storage: remaining byte counts of queued packets.
  logic [7:0]  credit_mem [CREDIT_SLOTS];
  logic [7:0]  rd_data_r;
  logic        mem_we, mem_re;
  logic [HW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;

  logic        out_valid_r;
  rtc_pkg::status_t status_r, status_nxt;
  logic [31:0] nwc_r, nwc_nxt;
  logic [15:0] count_out_r, count_out_nxt;
  logic [CW-1:0] retired_out_r;
  logic [CW+3:0] retired_ext;

  // Cursor check and fill level.
  logic [15:0] ri, wi, rm, wm;
  logic        fill_ok;
  logic [16:0] avail;

  always_comb begin
    ri = rc_r[31:16];
    wi = wc_r[31:16];
    rm = rc_r[15:0];
    wm = wc_r[15:0];
    fill_ok = desc_r && (ri < RC16) && (wi < RC16) &&
              (rm == 16'd0 || rm == rtc_pkg::MIRROR_ONES) &&
              (wm == 16'd0 || wm == rtc_pkg::MIRROR_ONES);
    if (rm == wm) begin
      fill_ok = fill_ok && (wi >= ri);
      avail   = 17'(wi - ri);
    end else begin
      fill_ok = fill_ok && (wi <= ri);
      avail   = RC17 - 17'(ri) + 17'(wi);
    end
  end

  // Walk step and decision helpers.
  logic [15:0] rem;
  logic [HW:0] head_inc;
  logic [HW-1:0] head_next_slot;
  logic [SW-1:0] slot_sum;
  logic [HW-1:0] enq_slot;
  logic        do_acct, commit, len_bad, room_bad;
  logic [16:0] cursor_idx;

  always_comb begin
    rem = {8'd0, rd_data_r};
    head_inc = (HW + 1)'(head_r) + (HW + 1)'(1);
    head_next_slot = (head_inc == SLOTS_H) ? '0 : head_inc[HW-1:0];
    slot_sum = SW'(head_r) + SW'(count_r);
    enq_slot = (slot_sum >= SLOTS_S) ? HW'(slot_sum - SLOTS_S) : HW'(slot_sum);
    do_acct = link_r && (op_r inside {rtc_pkg::OP_OBSERVE, rtc_pkg::OP_SUBMIT,
                                      rtc_pkg::OP_REPORT}) &&
              fill_ok_r && (avail_r <= {1'b0, bif_r});
    commit = !out_valid_r || out_ready;
    len_bad = (len_r == 8'd0) || (len_r > MAX_LEN) || len_r[0] ||
              (count_r >= SLOTS_C) ||
              (({1'b0, bif_r} + 17'(len_r)) > RC17);
    room_bad = !fill_ok_r || ((18'(avail_r) + 18'(len_r)) > RC18);
    cursor_idx = 17'(wc_r[31:16]) + 17'(len_r);
  end

  always_comb begin
    state_nxt     = state_r;
    drained_nxt   = drained_r;
    retired_nxt   = retired_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    bif_nxt       = bif_r;
    tally_nxt     = tally_r;
    mem_we        = 1'b0;
    mem_wa        = head_r;
    mem_wd        = 8'd0;
    mem_re        = 1'b0;
    mem_ra        = head_r;
    status_nxt    = rtc_pkg::ST_OBSERVED;
    nwc_nxt       = wc_r;
    count_out_nxt = 16'd0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt   = S_FILL;
          retired_nxt = '0;
        end
      end
      S_FILL: begin
        state_nxt = S_ACCT;
      end
      S_ACCT: begin
        state_nxt = S_DECIDE;
        if (do_acct) begin
          drained_nxt = bif_r - avail_r[15:0];
          bif_nxt     = avail_r[15:0];
          if (avail_r[15:0] != bif_r && count_r != '0) begin
            mem_re    = 1'b1;
            mem_ra    = head_r;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (drained_r < rem) begin
          // Partly drained packet: keep what is left at the head.
          mem_we    = 1'b1;
          mem_wa    = head_r;
          mem_wd    = rem[7:0] - drained_r[7:0];
          state_nxt = S_DECIDE;
        end else begin
          drained_nxt = drained_r - rem;
          head_nxt    = head_next_slot;
          count_nxt   = count_r - CW'(1);
          retired_nxt = retired_r + CW'(1);
          if (fce_r) begin
            tally_nxt = tally_r + 16'd1;
          end
          if (drained_nxt != 16'd0 && count_nxt != '0) begin
            mem_re = 1'b1;
            mem_ra = head_next_slot;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (commit) begin
          state_nxt = S_IDLE;
          case (op_r)
            rtc_pkg::OP_OBSERVE: begin
              status_nxt = rtc_pkg::ST_OBSERVED;
            end
            rtc_pkg::OP_SUBMIT: begin
              status_nxt = rtc_pkg::ST_DROPPED;
              if (link_r) begin
                if (len_bad || room_bad) begin
                  if (fce_r) begin
                    tally_nxt = tally_r + 16'd1;
                  end
                end else begin
                  status_nxt = rtc_pkg::ST_ACCEPTED;
                  mem_we     = 1'b1;
                  mem_wa     = enq_slot;
                  mem_wd     = len_r;
                  count_nxt  = count_r + CW'(1);
                  bif_nxt    = bif_r + 16'(len_r);
                  if (cursor_idx >= RC17) begin
                    nwc_nxt = {16'(cursor_idx - RC17), wc_r[15:0] ^ rtc_pkg::MIRROR_ONES};
                  end else begin
                    nwc_nxt = {cursor_idx[15:0], wc_r[15:0]};
                  end
                end
              end
            end
            rtc_pkg::OP_REPORT: begin
              status_nxt = rtc_pkg::ST_NO_REPORT;
              if (link_r && fce_r && tally_r != 16'd0) begin
                status_nxt    = rtc_pkg::ST_REPORTED;
                count_out_nxt = tally_r;
                tally_nxt     = 16'd0;
              end
            end
            default: begin
              status_nxt = rtc_pkg::ST_OBSERVED;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      credit_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= credit_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      bif_r       <= 16'd0;
      tally_r     <= 16'd0;
      fce_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      bif_r   <= bif_nxt;
      tally_r <= tally_nxt;
      if (cfg_we) begin
        fce_r <= cfg_wdata;
      end
      if (state_r == S_DECIDE && commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= in_operation;
      rc_r   <= in_read_cursor;
      wc_r   <= in_write_cursor;
      desc_r <= in_descriptor_ok;
      link_r <= in_link_ok;
      len_r  <= in_packet_length;
    end
    if (state_r == S_FILL) begin
      fill_ok_r <= fill_ok;
      avail_r   <= avail;
    end
    drained_r <= drained_nxt;
    retired_r <= retired_nxt;
    if (state_r == S_DECIDE && commit) begin
      status_r      <= status_nxt;
      nwc_r         <= nwc_nxt;
      count_out_r   <= count_out_nxt;
      retired_out_r <= retired_r;
    end
  end

  assign retired_ext = {4'd0, retired_out_r};

  assign in_ready              = (state_r == S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_next_write_cursor = nwc_r;
  assign out_completed_count   = count_out_r;
  assign out_retired_packets   = retired_ext[3:0];

endmodule

`default_nettype wire

// ----- rtl/core/rtc_checker.sv -----
// Port-level checks for the transmit-ring credit tracker, bound to its top level.
// Depends on rtc_pkg and ring_tx_credit_tracker.
`default_nettype none

module rtc_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   cfg_we,
  input wire                   cfg_wdata,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire [1:0]             in_operation,
  input wire [31:0]            in_read_cursor,
  input wire [31:0]            in_write_cursor,
  input wire                   in_descriptor_ok,
  input wire                   in_link_ok,
  input wire [7:0]             in_packet_length,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [2:0]             out_status,
  input wire [31:0]            out_next_write_cursor,
  input wire [15:0]            out_completed_count,
  input wire [3:0]             out_retired_packets
);

  // One request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another was in progress");

  // A given report always carries a nonzero count.
  a_report_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rtc_pkg::ST_REPORTED |-> out_completed_count != 16'd0)
    else $error("report given with an empty count");

  // Only a given report carries a count.
  a_count_only_on_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rtc_pkg::ST_REPORTED |-> out_completed_count == 16'd0)
    else $error("count shown on a result that is not a report");

  // A stalled result holds its status.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ring_tx_credit_tracker rtc_checker u_rtc_checker (.*);

`default_nettype wire
